[src/cabn_pkg.sv]
// Package for the class-aware box suppression block.
// Holds the box word types, controller state type, control structs and constants.
// Depends on nothing.
`timescale 1ns / 1ps
package cabn_pkg;

   localparam int FRAC_BITS     = 15;
   localparam int MAX_BOXES_DEF = 64;
   localparam int COORD_W       = 16;
   localparam int CONF_W        = 16;
   localparam int CLASS_W       = 8;
   localparam int THR_W         = 16;
   localparam logic [THR_W-1:0] THR_RESET = 16'd16384;
   // Guard term of the union, 1e-7 in units of 2^-(2*FRAC_BITS), rounded.
   localparam longint IOU_EPS = ((64'sd1 <<< (2 * FRAC_BITS)) + 64'sd5000000) / 64'sd10000000;

   typedef struct packed {
      logic [CONF_W-1:0]  confidence;
      logic [CLASS_W-1:0] class_id;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
   } cabn_box_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_RK_RDI,
      ST_RK_LATI,
      ST_RK_RDJ,
      ST_RK_CMP,
      ST_RK_WR,
      ST_NM_RDA,
      ST_NM_RDA2,
      ST_NM_LATA,
      ST_NM_RDB,
      ST_NM_RDB2,
      ST_NM_LATB,
      ST_NM_S1,
      ST_NM_S2,
      ST_NM_S3,
      ST_NM_S4,
      ST_EM_RDA,
      ST_EM_RD2,
      ST_EM_OUT
   } cabn_state_type;

   typedef struct packed {
      logic load_we;
      logic box_re;
      logic box_from_rank;
      logic rank_re;
      logic lat_conf_i;
      logic rank_clr;
      logic rank_cmp;
      logic tie_ok;
      logic rank_we;
      logic lat_a;
      logic run_s4;
      logic emit;
      logic emit_last;
      logic emit_ovf;
   } cabn_cmd_type;

   typedef struct packed {
      logic supp_rd;
      logic class_eq;
      logic out_free;
   } cabn_sts_type;

endpackage

[src/cabn_req_if.sv]
// Input channel carrying one box word with valid/ready handshake.
// Depends on cabn_pkg for field widths.
`timescale 1ns / 1ps
interface cabn_req_if
   import cabn_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CONF_W-1:0]  confidence;
   logic [CLASS_W-1:0] class_id;
   logic [COORD_W-1:0] left;
   logic [COORD_W-1:0] top;
   logic [COORD_W-1:0] right;
   logic [COORD_W-1:0] bottom;
   logic               final_box;

   modport source (output valid, confidence, class_id, left, top, right, bottom, final_box,
                   input ready);
   modport sink (input valid, confidence, class_id, left, top, right, bottom, final_box,
                 output ready);
endinterface

[src/cabn_rsp_if.sv]
// Result channel carrying one surviving box word with valid/ready handshake.
// Depends on cabn_pkg for field widths.
`timescale 1ns / 1ps
interface cabn_rsp_if
   import cabn_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CONF_W-1:0]  kept_confidence;
   logic [CLASS_W-1:0] kept_class;
   logic [COORD_W-1:0] kept_left;
   logic [COORD_W-1:0] kept_top;
   logic [COORD_W-1:0] kept_right;
   logic [COORD_W-1:0] kept_bottom;
   logic               last_kept;
   logic               overflowed;

   modport source (output valid, kept_confidence, kept_class, kept_left, kept_top,
                   kept_right, kept_bottom, last_kept, overflowed, input ready);
   modport sink (input valid, kept_confidence, kept_class, kept_left, kept_top,
                 kept_right, kept_bottom, last_kept, overflowed, output ready);
endinterface

[src/class_aware_box_nms.sv]
// Top level of the class-aware greedy box suppression block.
// Depends on cabn_pkg, cabn_req_if, cabn_rsp_if, cabn_ctrl and cabn_datapath.
//
// Usage: boxes enter on req_chan one word per cycle while the block is loading.
// The word with final_box set closes the list; req_chan.ready then stays low
// until each survivor is in the result register, in descending confidence
// (ties in arrival order), the last one marked with last_kept. Boxes beyond
// MAX_BOXES are dropped and every result of that list carries overflowed.
// csr_we/csr_wdata write the IoU threshold (Q1.15, reset value 0.5).
//
// Sequence for a list: ranking reads each box and compares it with every
// stored box, one memory read per compare. The suppression walk reads each
// ranked box and each later pair visited, and each same-class pair of
// unsuppressed boxes goes through the IoU multiplier pipeline (S1 to S4).
// Emission reads each ranked box up to the last survivor and waits while
// the receiver holds rsp_chan.ready low; the result register then holds its
// word. Reset empties the list, clears the output and restores the threshold.
`timescale 1ns / 1ps
module class_aware_box_nms
   import cabn_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   cabn_req_if.sink         req_chan,
   cabn_rsp_if.source       rsp_chan,
   input  logic             csr_we,
   input  logic [THR_W-1:0] csr_wdata
);
   localparam int IW = $clog2(MAX_BOXES);

   cabn_cmd_type  cmd;
   cabn_sts_type  sts;
   cabn_box_type  req_box;
   logic [IW-1:0] rd_idx;
   logic [IW-1:0] ld_addr;
   logic [IW-1:0] rank_val;
   logic          req_ready;

   assign req_box.confidence = req_chan.confidence;
   assign req_box.class_id   = req_chan.class_id;
   assign req_box.left       = req_chan.left;
   assign req_box.top        = req_chan.top;
   assign req_box.right      = req_chan.right;
   assign req_box.bottom     = req_chan.bottom;
   assign req_chan.ready     = req_ready;

   cabn_ctrl #(
      .MAX_BOXES (MAX_BOXES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_final (req_chan.final_box),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd),
      .rd_idx    (rd_idx),
      .ld_addr   (ld_addr),
      .rank_val  (rank_val)
   );

   cabn_datapath #(
      .MAX_BOXES (MAX_BOXES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_idx    (rd_idx),
      .ld_addr   (ld_addr),
      .rank_val  (rank_val),
      .req_box   (req_box),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .sts       (sts),
      .rsp_chan  (rsp_chan)
   );

endmodule

[src/cabn_datapath.sv]
// Datapath: box, rank and flag memories, ranking counter, IoU pipeline and output register.
// Depends on cabn_pkg and cabn_rsp_if; driven by cabn_ctrl commands.
`timescale 1ns / 1ps
module cabn_datapath
   import cabn_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cabn_cmd_type                 cmd,
   input  logic [$clog2(MAX_BOXES)-1:0] rd_idx,
   input  logic [$clog2(MAX_BOXES)-1:0] ld_addr,
   input  logic [$clog2(MAX_BOXES)-1:0] rank_val,
   input  cabn_box_type                 req_box,
   input  logic                         csr_we,
   input  logic [THR_W-1:0]             csr_wdata,
   output cabn_sts_type                 sts,
   cabn_rsp_if.source                   rsp_chan
);
   localparam int IW = $clog2(MAX_BOXES);

   logic [4*COORD_W-1:0]        corner_mem [MAX_BOXES];
   logic [CONF_W+CLASS_W-1:0]   sc_mem     [MAX_BOXES];
   logic [IW-1:0]               rank_mem   [MAX_BOXES];
   logic                        supp_mem   [MAX_BOXES];

   logic [4*COORD_W-1:0]      corner_q_ff;
   logic [CONF_W+CLASS_W-1:0] sc_q_ff;
   logic                      supp_q_ff;
   logic [IW-1:0]             rank_q_ff;
   logic [IW-1:0]             b_idx_ff;
   logic [IW-1:0]             box_addr;
   logic [IW-1:0]             rank_cnt_ff;
   logic [CONF_W-1:0]         conf_i_ff;
   logic [4*COORD_W-1:0]      a_corner_ff;
   logic [CLASS_W-1:0]        a_class_ff;
   logic [THR_W-1:0]          thr_ff;

   logic [COORD_W-1:0] al, at, ar, ab, bl, bt, br, bb;
   logic [COORD_W-1:0] min_r, max_l, min_b, max_t;
   logic signed [17:0] iw_raw, ih_raw;
   logic [16:0]        iw_ff, ih_ff;
   logic signed [17:0] wa_ff, ha_ff, wb_ff, hb_ff;
   logic [33:0]        inter_ff;
   logic signed [35:0] area_a_ff, area_b_ff;
   logic signed [37:0] den_ff;
   logic signed [63:0] lhs;
   logic signed [54:0] rhs;
   logic               suppress;
   logic [CONF_W-1:0]  conf_j;

   logic                      out_valid_ff;
   logic [4*COORD_W-1:0]      out_corner_ff;
   logic [CONF_W+CLASS_W-1:0] out_sc_ff;
   logic                      out_last_ff;
   logic                      out_ovf_ff;

   assign box_addr = cmd.box_from_rank ? rank_q_ff : rd_idx;

   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         corner_mem[ld_addr] <= {req_box.bottom, req_box.right, req_box.top, req_box.left};
         sc_mem[ld_addr]     <= {req_box.class_id, req_box.confidence};
      end
      if (cmd.load_we) begin
         supp_mem[ld_addr] <= 1'b0;
      end else if (cmd.run_s4 && suppress) begin
         supp_mem[b_idx_ff] <= 1'b1;
      end
      if (cmd.rank_we) begin
         rank_mem[rank_cnt_ff] <= rank_val;
      end
      if (cmd.box_re) begin
         corner_q_ff <= corner_mem[box_addr];
         sc_q_ff     <= sc_mem[box_addr];
         supp_q_ff   <= supp_mem[box_addr];
         b_idx_ff    <= box_addr;
      end
      if (cmd.rank_re) begin
         rank_q_ff <= rank_mem[rd_idx];
      end
   end

   // Rank of box i is the number of boxes that sort ahead of it.
   assign conf_j = sc_q_ff[CONF_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.lat_conf_i) begin
         conf_i_ff <= conf_j;
      end
      if (cmd.rank_clr) begin
         rank_cnt_ff <= '0;
      end else if (cmd.rank_cmp &&
                   ((conf_j > conf_i_ff) || ((conf_j == conf_i_ff) && cmd.tie_ok))) begin
         rank_cnt_ff <= rank_cnt_ff + IW'(1);
      end
      if (cmd.lat_a) begin
         a_corner_ff <= corner_q_ff;
         a_class_ff  <= sc_q_ff[CONF_W+CLASS_W-1:CONF_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign {ab, ar, at, al} = a_corner_ff;
   assign {bb, br, bt, bl} = corner_q_ff;

   always_comb begin
      min_r  = (ar < br) ? ar : br;
      max_l  = (al > bl) ? al : bl;
      min_b  = (ab < bb) ? ab : bb;
      max_t  = (at > bt) ? at : bt;
      iw_raw = $signed({2'b00, min_r}) - $signed({2'b00, max_l});
      ih_raw = $signed({2'b00, min_b}) - $signed({2'b00, max_t});
   end

   // Register stages: differences, products, guarded union; the final compare is combinational.
   always_ff @(posedge clock) begin
      iw_ff     <= iw_raw[17] ? 17'd0 : iw_raw[16:0];
      ih_ff     <= ih_raw[17] ? 17'd0 : ih_raw[16:0];
      wa_ff     <= $signed({2'b00, ar}) - $signed({2'b00, al});
      ha_ff     <= $signed({2'b00, ab}) - $signed({2'b00, at});
      wb_ff     <= $signed({2'b00, br}) - $signed({2'b00, bl});
      hb_ff     <= $signed({2'b00, bb}) - $signed({2'b00, bt});
      inter_ff  <= iw_ff * ih_ff;
      area_a_ff <= wa_ff * ha_ff;
      area_b_ff <= wb_ff * hb_ff;
      den_ff    <= 38'(area_a_ff) + 38'(area_b_ff) - $signed({4'b0000, inter_ff})
                   + 38'(IOU_EPS);
   end

   always_comb begin
      lhs      = $signed({30'd0, inter_ff}) <<< FRAC_BITS;
      rhs      = $signed({1'b0, thr_ff}) * den_ff;
      suppress = !den_ff[37] && (lhs > 64'(rhs));
   end

   assign sts.supp_rd  = supp_q_ff;
   assign sts.class_eq = (sc_q_ff[CONF_W+CLASS_W-1:CONF_W] == a_class_ff);
   assign sts.out_free = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         out_corner_ff <= corner_q_ff;
         out_sc_ff     <= sc_q_ff;
         out_last_ff   <= cmd.emit_last;
         out_ovf_ff    <= cmd.emit_ovf;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.kept_confidence = out_sc_ff[CONF_W-1:0];
   assign rsp_chan.kept_class      = out_sc_ff[CONF_W+CLASS_W-1:CONF_W];
   assign rsp_chan.kept_left       = out_corner_ff[COORD_W-1:0];
   assign rsp_chan.kept_top        = out_corner_ff[2*COORD_W-1:COORD_W];
   assign rsp_chan.kept_right      = out_corner_ff[3*COORD_W-1:2*COORD_W];
   assign rsp_chan.kept_bottom     = out_corner_ff[4*COORD_W-1:3*COORD_W];
   assign rsp_chan.last_kept       = out_last_ff;
   assign rsp_chan.overflowed      = out_ovf_ff;

endmodule

[src/cabn_ctrl.sv]
// Controller: sequences load, rank, suppression walk and emission with loop counters.
// Depends on cabn_pkg; commands the cabn_datapath.
`timescale 1ns / 1ps
module cabn_ctrl
   import cabn_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_final,
   output logic                         req_ready,
   input  cabn_sts_type                 sts,
   output cabn_cmd_type                 cmd,
   output logic [$clog2(MAX_BOXES)-1:0] rd_idx,
   output logic [$clog2(MAX_BOXES)-1:0] ld_addr,
   output logic [$clog2(MAX_BOXES)-1:0] rank_val
);
   localparam int IW = $clog2(MAX_BOXES);
   localparam int CW = $clog2(MAX_BOXES + 1);

   cabn_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic [CW-1:0]  i_ff, i_in;
   logic [CW-1:0]  j_ff, j_in;
   logic [IW-1:0]  last_ff, last_in;
   logic [CW-1:0]  i_nxt, j_nxt;
   logic           accept;

   assign i_nxt  = i_ff + CW'(1);
   assign j_nxt  = j_ff + CW'(1);
   assign accept = req_valid && (state_ff == ST_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_final) state_in = ST_RK_RDI;
         end
         ST_RK_RDI:  state_in = ST_RK_LATI;
         ST_RK_LATI: state_in = ST_RK_RDJ;
         ST_RK_RDJ:  state_in = ST_RK_CMP;
         ST_RK_CMP:  state_in = (j_nxt == count_ff) ? ST_RK_WR : ST_RK_RDJ;
         ST_RK_WR:   state_in = (i_nxt == count_ff) ? ST_NM_RDA : ST_RK_RDI;
         ST_NM_RDA:  state_in = ST_NM_RDA2;
         ST_NM_RDA2: state_in = ST_NM_LATA;
         ST_NM_LATA: begin
            if (sts.supp_rd || (i_nxt == count_ff)) begin
               state_in = (i_nxt == count_ff) ? ST_EM_RDA : ST_NM_RDA;
            end else begin
               state_in = ST_NM_RDB;
            end
         end
         ST_NM_RDB:  state_in = ST_NM_RDB2;
         ST_NM_RDB2: state_in = ST_NM_LATB;
         ST_NM_LATB: begin
            if (sts.supp_rd || !sts.class_eq) begin
               if (j_nxt == count_ff) begin
                  state_in = (i_nxt == count_ff) ? ST_EM_RDA : ST_NM_RDA;
               end else begin
                  state_in = ST_NM_RDB;
               end
            end else begin
               state_in = ST_NM_S1;
            end
         end
         ST_NM_S1: state_in = ST_NM_S2;
         ST_NM_S2: state_in = ST_NM_S3;
         ST_NM_S3: state_in = ST_NM_S4;
         ST_NM_S4: begin
            if (j_nxt == count_ff) begin
               state_in = (i_nxt == count_ff) ? ST_EM_RDA : ST_NM_RDA;
            end else begin
               state_in = ST_NM_RDB;
            end
         end
         ST_EM_RDA: state_in = ST_EM_RD2;
         ST_EM_RD2: state_in = ST_EM_OUT;
         ST_EM_OUT: begin
            if (sts.supp_rd || sts.out_free) begin
               state_in = (i_ff[IW-1:0] == last_ff) ? ST_LOAD : ST_EM_RDA;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rd_idx    = i_ff[IW-1:0];
      ld_addr   = count_ff[IW-1:0];
      rank_val  = i_ff[IW-1:0];
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      last_in   = last_ff;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            i_in      = '0;
            if (accept) begin
               if (count_ff < CW'(MAX_BOXES)) begin
                  cmd.load_we = 1'b1;
                  count_in    = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_RK_RDI: begin
            cmd.box_re = 1'b1;
         end
         ST_RK_LATI: begin
            cmd.lat_conf_i = 1'b1;
            cmd.rank_clr   = 1'b1;
            j_in           = '0;
         end
         ST_RK_RDJ: begin
            cmd.box_re = 1'b1;
            rd_idx     = j_ff[IW-1:0];
         end
         ST_RK_CMP: begin
            cmd.rank_cmp = 1'b1;
            cmd.tie_ok   = (j_ff < i_ff);
            j_in         = j_nxt;
         end
         ST_RK_WR: begin
            cmd.rank_we = 1'b1;
            i_in        = (i_nxt == count_ff) ? '0 : i_nxt;
         end
         ST_NM_RDA, ST_NM_RDB: begin
            cmd.rank_re = 1'b1;
            rd_idx      = (state_ff == ST_NM_RDB) ? j_ff[IW-1:0] : i_ff[IW-1:0];
         end
         ST_NM_RDA2, ST_NM_RDB2, ST_EM_RD2: begin
            cmd.box_re        = 1'b1;
            cmd.box_from_rank = 1'b1;
         end
         ST_NM_LATA: begin
            if (!sts.supp_rd) begin
               cmd.lat_a = 1'b1;
               last_in   = i_ff[IW-1:0];
               j_in      = i_nxt;
            end
            if (sts.supp_rd || (i_nxt == count_ff)) begin
               i_in = (i_nxt == count_ff) ? '0 : i_nxt;
            end
         end
         ST_NM_LATB, ST_NM_S4: begin
            cmd.run_s4 = (state_ff == ST_NM_S4);
            if ((state_ff == ST_NM_S4) || sts.supp_rd || !sts.class_eq) begin
               j_in = j_nxt;
               if (j_nxt == count_ff) begin
                  i_in = (i_nxt == count_ff) ? '0 : i_nxt;
               end
            end
         end
         ST_EM_RDA: begin
            cmd.rank_re = 1'b1;
         end
         ST_EM_OUT: begin
            if (sts.supp_rd || sts.out_free) begin
               cmd.emit      = !sts.supp_rd;
               cmd.emit_last = (i_ff[IW-1:0] == last_ff);
               cmd.emit_ovf  = ovf_ff;
               i_in          = i_nxt;
               if (i_ff[IW-1:0] == last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  i_in     = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(MAX_BOXES))
      else $error("box count beyond capacity");
   assert property (@(posedge clock) disable iff (reset) cmd.emit |-> sts.out_free)
      else $error("result written while output register still held");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EM_OUT && state_in == ST_LOAD) |=> (count_ff == '0 && !ovf_ff))
      else $error("list state not cleared after emission");
   assert property (@(posedge clock) disable iff (reset) cmd.rank_we |-> (i_ff < count_ff))
      else $error("rank written for a box that is not stored");

endmodule
